// File: rtl/sh64w_pkg.sv
// Shared constants, command types and bit-mixing functions for the 64-bit
// word-stream string hash. No dependencies; imported by sh64w_dp, sh64w_ctrl and the top level.
package sh64w_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = WORD_W / 2;

    localparam logic [WORD_W-1:0] MIX_MULT = 64'h3C79AC492BA7B653;
    localparam logic [HALF_W-1:0] MULT_LO  = MIX_MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0] MULT_HI  = MIX_MULT[WORD_W-1:HALF_W];
    localparam int unsigned MIX_ROT  = 21;
    localparam int unsigned XS_RIGHT = 7;
    localparam int unsigned XS_LEFT  = 9;

    // Partial-product steps of the shared 32x32 multiplier.
    typedef logic [1:0] mul_sel_t;
    localparam mul_sel_t MUL_LO_LO = 2'd0;
    localparam mul_sel_t MUL_HI_LO = 2'd1;
    localparam mul_sel_t MUL_LO_HI = 2'd2;

    typedef struct packed {
        logic     op_load_chunk;
        logic     op_load_final;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     acc_first;
        logic     acc_clear;
        logic     prod_clear;
        logic     out_load;
    } sh64w_cmd_t;

    function automatic logic [WORD_W-1:0] mix_pre(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] rl;
        logic [WORD_W-1:0] rr;
        rl = (v << MIX_ROT) | (v >> (WORD_W - MIX_ROT));
        rr = (v >> MIX_ROT) | (v << (WORD_W - MIX_ROT));
        return v ^ rl ^ rr;
    endfunction

    function automatic logic [WORD_W-1:0] acc_shift(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] t;
        t = v ^ (v >> XS_RIGHT);
        return t ^ (t << XS_LEFT);
    endfunction

    function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < WORD_W / 8; i++)
        begin
            r[8*i +: 8] = v[WORD_W - 8 - 8*i +: 8];
        end
        return r;
    endfunction

endpackage

// File: rtl/sh64w_word_if.sv
// Input channel of the string hash: one 64-bit string chunk and its flags
// per word. No dependencies.
interface sh64w_word_if;
    logic        valid;
    logic        ready;
    logic [63:0] chunk;
    logic        first_of_string;
    logic        last_of_string;
    logic        empty_string;

    modport source(output valid, chunk, first_of_string, last_of_string, empty_string,
                   input ready);
    modport sink(input valid, chunk, first_of_string, last_of_string, empty_string,
                 output ready);
endinterface

// File: rtl/sh64w_hash_if.sv
// Output channel of the string hash: one finished 64-bit hash per word.
// No dependencies.
interface sh64w_hash_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source(output valid, hash_value, input ready);
    modport sink(input valid, hash_value, output ready);
endinterface

// File: rtl/sh64w_dp.sv
// Datapath of the string hash: operand, product, accumulator and result
// registers around one shared 32x32 multiplier. Depends on sh64w_pkg.
module sh64w_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sh64w_pkg::sh64w_cmd_t      cmd,
    input  logic [sh64w_pkg::WORD_W-1:0] chunk,
    output logic [sh64w_pkg::WORD_W-1:0] hash_value
);
    import sh64w_pkg::*;

    logic [WORD_W-1:0]   op_reg;
    logic [WORD_W-1:0]   prod_reg;
    logic [WORD_W-1:0]   acc_reg;
    logic [WORD_W-1:0]   hash_reg;
    logic [WORD_W-1:0]   acc_next;
    logic [HALF_W-1:0]   mul_a;
    logic [HALF_W-1:0]   mul_b;
    logic [WORD_W-1:0]   mul_p;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_LO_LO:
            begin
                mul_a = op_reg[HALF_W-1:0];
                mul_b = MULT_LO;
            end
            MUL_HI_LO:
            begin
                mul_a = op_reg[WORD_W-1:HALF_W];
                mul_b = MULT_LO;
            end
            MUL_LO_HI:
            begin
                mul_a = op_reg[HALF_W-1:0];
                mul_b = MULT_HI;
            end
            default:
            begin
                mul_a = op_reg[HALF_W-1:0];
                mul_b = MULT_LO;
            end
        endcase
    end

    assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

    assign acc_next = cmd.acc_first ? prod_reg : (acc_shift(acc_reg) + prod_reg);

    // Operand register: the pre-mixed chunk, or the byte-swapped accumulator
    // for the final multiply of a string.
    always_ff @(posedge clk)
    begin
        if (cmd.op_load_chunk)
            op_reg <= mix_pre(chunk);
        else if (cmd.op_load_final)
            op_reg <= swap_bytes(acc_next);
    end

    // The low 64 bits of op * MIX_MULT take three partial products; the two
    // cross terms only touch the upper half.
    always_ff @(posedge clk)
    begin
        if (cmd.prod_clear)
            prod_reg <= '0;
        else if (cmd.mul_en)
        begin
            if (cmd.mul_sel == MUL_LO_LO)
                prod_reg <= mul_p;
            else
                prod_reg[WORD_W-1:HALF_W] <= prod_reg[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (cmd.acc_clear)
            acc_reg <= '0;
        else if (cmd.acc_load)
            acc_reg <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            hash_reg <= prod_reg;
    end

    assign hash_value = hash_reg;

endmodule

// File: rtl/sh64w_ctrl.sv
// Controller of the string hash: sequences accept, three multiply steps,
// the accumulator update and the final mix, and owns the output valid.
// Depends on sh64w_pkg.
module sh64w_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  first_of_string,
    input  logic                  last_of_string,
    input  logic                  empty_string,
    output logic                  in_ready,
    input  logic                  out_ready,
    output logic                  out_valid,
    output sh64w_pkg::sh64w_cmd_t cmd
);
    import sh64w_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL0 = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       first_reg;
    logic       first_next;
    logic       last_reg;
    logic       last_next;
    logic       final_reg;
    logic       final_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        last_next  = last_reg;
        final_next = final_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mul_sel = MUL_LO_LO;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (empty_string)
                    begin
                        cmd.acc_clear  = 1'b1;
                        cmd.prod_clear = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        cmd.op_load_chunk = 1'b1;
                        first_next        = first_of_string;
                        last_next         = last_of_string;
                        final_next        = 1'b0;
                        state_next        = S_MUL0;
                    end
                end
            end
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LO_LO;
                state_next  = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HI_LO;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LO_HI;
                state_next  = final_reg ? S_OUT : S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_load  = 1'b1;
                cmd.acc_first = first_reg;
                if (last_reg)
                begin
                    cmd.op_load_final = 1'b1;
                    final_next        = 1'b1;
                    state_next        = S_MUL0;
                end
                else
                    state_next = S_IDLE;
            end
            S_OUT:
            begin
                // Wait here only while the previous hash is still unclaimed.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= 1'b0;
            last_reg      <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/string_hash64_word_stream_top.sv
// Top level of the 64-bit word-stream string hash.
// Depends on sh64w_pkg, sh64w_word_if, sh64w_hash_if, sh64w_ctrl and sh64w_dp.
//
// Usage:
//   words  (sink)   : one 64-bit little-endian chunk per word, presented from
//                     the string's end toward its start, with first, last and
//                     empty flags. A word is taken when valid and ready are high.
//   hashes (source) : one 64-bit hash per string, after the word that carries
//                     last_of_string or empty_string.
// Flow control: after a chunk is accepted, ready stays low through three steps
// of the shared 32x32 multiplier and then the accumulator update, so the next
// word is taken only once the current one is done.
// A word that ends a string adds the final multiply after that update: ready
// returns in the same cycle that its hash becomes valid.
// An empty string loads a zero hash.
// The shared multiplier is used three times per 64-bit product.
// The hash sits in an output register, so a stalled receiver only holds the
// block when the next hash is ready to be loaded; further chunks are taken
// meanwhile. Reset clears the accumulator to zero and the output valid.
module string_hash64_word_stream_top (
    input  logic         clk,
    input  logic         rst_n,
    sh64w_word_if.sink   words,
    sh64w_hash_if.source hashes
);
    import sh64w_pkg::*;

    sh64w_cmd_t cmd;

    sh64w_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (words.valid),
        .first_of_string (words.first_of_string),
        .last_of_string  (words.last_of_string),
        .empty_string    (words.empty_string),
        .in_ready        (words.ready),
        .out_ready       (hashes.ready),
        .out_valid       (hashes.valid),
        .cmd             (cmd)
    );

    sh64w_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .chunk      (words.chunk),
        .hash_value (hashes.hash_value)
    );

    // At most one of chunk load, multiply, accumulator load, output load and accumulator clear is issued in any cycle.
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.op_load_chunk, cmd.mul_en, cmd.acc_load, cmd.out_load, cmd.acc_clear}))
        else $error("overlapping datapath commands");

    // A new hash never overwrites one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!hashes.valid || hashes.ready))
        else $error("hash register overwritten while stalled");

    // Words are processed one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (words.valid && words.ready) |=> !words.ready)
        else $error("word accepted while previous word still in work");

    // The hash register is loaded only as the sequence leaves its last step, and each load sets the output valid.
    a_load_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> hashes.valid)
        else $error("hash loaded without valid");

endmodule
